// ===== hw/rtl/mcsw_pkg.sv =====
// Package for the multi-channel supervisor watchdog.
// Holds item types, operation, action and priority codes, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package mcsw_pkg;

   // defaults for the top-level parameters
   localparam int CHANNELS_DEFAULT      = 16;
   localparam int RESTART_LIMIT_DEFAULT = 3;

   // operation codes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   // action codes
   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_RESTART = 2'd1;
   localparam logic [1:0] ACT_REPORT  = 2'd2;

   // priority codes
   localparam logic [1:0] PRIO_CRITICAL = 2'd0;
   localparam logic [1:0] PRIO_HIGH     = 2'd1;
   localparam logic [1:0] PRIO_NORMAL   = 2'd2;
   localparam logic [1:0] PRIO_LOW      = 2'd3;

   // configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_CRITICAL = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_HIGH     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_NORMAL   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_LOW      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCAN_INTERVAL    = 3'd4;

   // register reset values
   localparam logic [31:0] RST_TIMEOUT_CRITICAL = 32'd1000;
   localparam logic [31:0] RST_TIMEOUT_HIGH     = 32'd2000;
   localparam logic [31:0] RST_TIMEOUT_NORMAL   = 32'd5000;
   localparam logic [31:0] RST_TIMEOUT_LOW      = 32'd10000;
   localparam logic [31:0] RST_SCAN_INTERVAL    = 32'd1000;

   // number of client indexes the item can address
   localparam int CLIENT_W   = 4;
   localparam int CLIENT_MAX = 1 << CLIENT_W;

   typedef struct packed {
      logic        operation;
      logic [15:0] delta_ms;
      logic [3:0]  client;
      logic        client_running;
      logic [1:0]  client_priority;
      logic [31:0] last_seen_in;
      logic [31:0] time_now_ms;
   } req_type;

   typedef struct packed {
      logic        scan_due;
      logic [1:0]  action;
      logic [3:0]  client_out;
      logic [3:0]  restart_number;
      logic [31:0] last_seen_out;
   } rsp_type;

   // per-client supervision entry kept in memory
   typedef struct packed {
      logic       reported;
      logic [3:0] count;
   } entry_type;

endpackage

// ===== hw/rtl/multi_channel_supervisor_watchdog_top.sv =====
// Top level of the multi-channel supervisor watchdog.
// Depends on mcsw_pkg for item types, codes and reset values.
`timescale 1ns / 1ps

// Usage
//  req_*: valid/ready input channel. A tick item (operation = tick) adds
//    delta_ms to the saturating uptime and interval timer and flags scan_due
//    when the scan interval is reached. A check item tests one client for
//    silence against the timeout of its priority and may order a restart or
//    report that the restart limit was exceeded (once per client).
//  rsp_*: valid/ready result channel, exactly one result item per input item,
//    in order.
//  csr_*: plain write port for the five configuration registers; write only
//    while the block is idle. Indexes past the last register are ignored.
//  Path: an accepted item is registered in stage 2, then in the result register.
//  Throughput: one item per cycle while rsp_ready is high. Each check does a
//    read-modify-write of its client entry in a memory with a registered read; a
//    write-back forwarding register covers a check of the same client right after it.
//  Reset: synchronous, active high. Registers return to their defaults, uptime
//    and interval timer clear, and per-entry valid bits make every restart
//    count and reported flag read as zero at once (no clearing pass).
//  Stall: while rsp_ready is low the result register holds, the second stage
//    holds its item and req_ready drops once both are full.
module multi_channel_supervisor_watchdog_top #(
   parameter int CHANNELS      = mcsw_pkg::CHANNELS_DEFAULT,
   parameter int RESTART_LIMIT = mcsw_pkg::RESTART_LIMIT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  mcsw_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output mcsw_pkg::rsp_type                rsp_data,
   input  logic                             csr_write_en,
   input  logic [mcsw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                      csr_wdata
);

   // only client indexes that the item can carry need storage
   localparam int ENTRIES = (CHANNELS < mcsw_pkg::CLIENT_MAX) ? CHANNELS : mcsw_pkg::CLIENT_MAX;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [8:0] CHANNELS_CMP = 9'(CHANNELS);
   localparam logic [3:0] LIMIT_CNT    = 4'(RESTART_LIMIT);

   // configuration registers
   logic [31:0] tmo_critical_ff, tmo_high_ff, tmo_normal_ff, tmo_low_ff, scan_interval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tmo_critical_ff  <= mcsw_pkg::RST_TIMEOUT_CRITICAL;
         tmo_high_ff      <= mcsw_pkg::RST_TIMEOUT_HIGH;
         tmo_normal_ff    <= mcsw_pkg::RST_TIMEOUT_NORMAL;
         tmo_low_ff       <= mcsw_pkg::RST_TIMEOUT_LOW;
         scan_interval_ff <= mcsw_pkg::RST_SCAN_INTERVAL;
      end else if (csr_write_en) begin
         unique case (csr_index)
            mcsw_pkg::CSR_TIMEOUT_CRITICAL: tmo_critical_ff  <= csr_wdata;
            mcsw_pkg::CSR_TIMEOUT_HIGH:     tmo_high_ff      <= csr_wdata;
            mcsw_pkg::CSR_TIMEOUT_NORMAL:   tmo_normal_ff    <= csr_wdata;
            mcsw_pkg::CSR_TIMEOUT_LOW:      tmo_low_ff       <= csr_wdata;
            mcsw_pkg::CSR_SCAN_INTERVAL:    scan_interval_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake: result register, then stage 2, then the input side
   logic rsp_valid_ff, rsp_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_free, s2_adv, accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_adv    = s2_valid_ff && out_free;
   assign req_ready = !s2_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   // ---------------- stage 1: timers, limit select, expiry ----------------
   logic        is_tick, is_check;
   logic [32:0] uptime_sum, elapsed_sum;
   logic [31:0] uptime_ff, uptime_in, elapsed_ff, elapsed_in, elapsed_sat;
   logic        scan_hit;
   logic [31:0] limit, gap;
   logic        expired, in_range, check_live;
   logic [IDX_W-1:0] rd_idx;

   assign is_tick  = (req_data.operation == mcsw_pkg::OP_TICK);
   assign is_check = (req_data.operation == mcsw_pkg::OP_CHECK);

   assign uptime_sum  = {1'b0, uptime_ff}  + {17'b0, req_data.delta_ms};
   assign elapsed_sum = {1'b0, elapsed_ff} + {17'b0, req_data.delta_ms};
   assign elapsed_sat = elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];
   assign scan_hit    = (elapsed_sat >= scan_interval_ff);

   always_comb begin
      uptime_in  = uptime_ff;
      elapsed_in = elapsed_ff;
      if (accept && is_tick) begin
         uptime_in  = uptime_sum[32] ? 32'hFFFF_FFFF : uptime_sum[31:0];
         elapsed_in = scan_hit ? 32'd0 : elapsed_sat;
      end
   end

   always_comb begin
      unique case (req_data.client_priority)
         mcsw_pkg::PRIO_CRITICAL: limit = tmo_critical_ff;
         mcsw_pkg::PRIO_HIGH:     limit = tmo_high_ff;
         mcsw_pkg::PRIO_NORMAL:   limit = tmo_normal_ff;
         default:                 limit = tmo_low_ff;
      endcase
   end

   // gap is taken modulo 2^32; a never-updated client gets the uptime as grace
   assign gap        = req_data.time_now_ms - req_data.last_seen_in;
   assign expired    = (req_data.last_seen_in == 32'd0) ? (uptime_ff >= limit) : (gap >= limit);
   assign in_range   = (9'(req_data.client) < CHANNELS_CMP);
   assign check_live = is_check && in_range && req_data.client_running;
   assign rd_idx     = req_data.client[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         uptime_ff  <= '0;
         elapsed_ff <= '0;
      end else begin
         uptime_ff  <= uptime_in;
         elapsed_ff <= elapsed_in;
      end
   end

   // stage 2 item registers
   logic             s2_tick_ff, s2_scan_ff, s2_hit_ff;
   logic [3:0]       s2_client_ff;
   logic [31:0]      s2_last_ff;
   logic [IDX_W-1:0] s2_idx_ff;

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (accept)      s2_valid_in = 1'b1;
      else if (s2_adv) s2_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s2_valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s2_tick_ff   <= is_tick;
         s2_scan_ff   <= is_tick && scan_hit;
         s2_hit_ff    <= check_live && expired;
         s2_client_ff <= req_data.client;
         s2_last_ff   <= req_data.last_seen_in;
         s2_idx_ff    <= rd_idx;
      end
   end

   // ---------------- client entry memory ----------------
   mcsw_pkg::entry_type entry_mem [ENTRIES];
   mcsw_pkg::entry_type rd_data_ff, fwd_data_ff, entry_cur, entry_new;
   logic [ENTRIES-1:0]  written_ff, written_in;
   logic                rd_written_ff;
   logic                fwd_valid_ff;
   logic [IDX_W-1:0]    fwd_idx_ff;
   logic                mem_re, mem_we;

   assign mem_re = accept && is_check && in_range;

   always_ff @(posedge clock) begin
      if (mem_we) entry_mem[s2_idx_ff] <= entry_new;
      if (mem_re) begin
         rd_data_ff    <= entry_mem[rd_idx];
         rd_written_ff <= written_ff[rd_idx];
      end
   end

   // valid bits: an entry never written since reset reads as zero
   always_comb begin
      written_in = written_ff;
      if (mem_we) written_in[s2_idx_ff] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff   <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         written_ff <= written_in;
         if (mem_we) fwd_valid_ff <= 1'b1;
      end
   end

   // last written entry; newer than the memory read when both hit one client
   always_ff @(posedge clock) begin
      if (mem_we) begin
         fwd_idx_ff  <= s2_idx_ff;
         fwd_data_ff <= entry_new;
      end
   end

   // ---------------- stage 2: restart / report decision ----------------
   mcsw_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [1:0] act;
   logic [3:0] rnum;

   always_comb begin
      if (fwd_valid_ff && (fwd_idx_ff == s2_idx_ff)) entry_cur = fwd_data_ff;
      else if (rd_written_ff)                        entry_cur = rd_data_ff;
      else                                           entry_cur = '0;

      entry_new = entry_cur;
      act       = mcsw_pkg::ACT_NONE;
      rnum      = 4'd0;
      if (s2_hit_ff) begin
         if (entry_cur.count < LIMIT_CNT) begin
            entry_new.count = entry_cur.count + 4'd1;
            act             = mcsw_pkg::ACT_RESTART;
            rnum            = entry_new.count;
         end else if (!entry_cur.reported) begin
            entry_new.reported = 1'b1;
            act                = mcsw_pkg::ACT_REPORT;
            rnum               = entry_cur.count;
         end
      end
   end

   assign mem_we = s2_adv && (act != mcsw_pkg::ACT_NONE);

   always_comb begin
      rsp_data_in.scan_due       = s2_scan_ff;
      rsp_data_in.action         = act;
      rsp_data_in.client_out     = s2_tick_ff ? 4'd0 : s2_client_ff;
      rsp_data_in.restart_number = rnum;
      rsp_data_in.last_seen_out  = (act != mcsw_pkg::ACT_NONE) ? s2_last_ff : 32'd0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s2_adv)         rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (s2_adv) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- assertions ----------------
   a_accept_fills_s2: assert property (@(posedge clock) disable iff (reset)
      accept |=> s2_valid_ff)
      else $error("accepted item did not reach stage 2");

   a_restart_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.restart_number <= LIMIT_CNT))
      else $error("restart number above limit");

   a_uptime_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (uptime_ff >= $past(uptime_ff)))
      else $error("uptime decreased");

   a_action_not_on_tick: assert property (@(posedge clock) disable iff (reset)
      s2_adv && s2_tick_ff |=> (rsp_data_ff.action == mcsw_pkg::ACT_NONE))
      else $error("tick produced an action");

endmodule

// ===== dv/tb_multi_channel_supervisor_watchdog_top.sv =====
// Self-checking testbench for multi_channel_supervisor_watchdog_top.
// Drives tick and check items with bursty valid/ready traffic and compares every
// result with an in-bench supervision predictor. Depends on mcsw_pkg and the RTL.
`timescale 1ns / 1ps

module tb_multi_channel_supervisor_watchdog_top;
   import mcsw_pkg::*;

   localparam int FLEET         = CHANNELS_DEFAULT;
   localparam int RESTART_LIMIT = RESTART_LIMIT_DEFAULT;
   // The scan walker only covers clients below WALKED, the top two are for the checks
   // made at the largest limits; noise checks on those two have client_running low.
   localparam int WALKED        = FLEET - 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_FIRST = CSR_SCAN_INTERVAL + 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LAST  = '1;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0] csr_wdata;

   multi_channel_supervisor_watchdog_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // ---------------------------------------------------------------------
   // Supervision predictor: our own copy of registers and per-client state
   // ---------------------------------------------------------------------
   logic [31:0] timeout_ms [4];          // indexed by priority code
   logic [31:0] scan_interval;
   logic [31:0] up_ms;
   logic [31:0] since_scan_ms;
   logic [3:0]  restarts [FLEET];
   logic        reported [FLEET];

   rsp_type verdicts_due [$];            // expected results, oldest first

   // simulated client fleet that the scan walker reports on
   logic [31:0] wall_ms;
   logic [31:0] fleet_seen [FLEET];
   logic        fleet_running [FLEET];
   logic [1:0]  fleet_prio [FLEET];

   int mismatches    = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int scans_seen    = 0;
   int restarts_seen = 0;
   int reports_seen  = 0;
   int csr_writes    = 0;
   int burst_left    = 0;
   int ready_hold    = 0;

   // Works out the result of one item and advances the predicted state.
   function automatic rsp_type supervise(input req_type it);
      rsp_type     v;
      logic [32:0] sum;
      logic [31:0] lim;
      logic [31:0] gap;
      logic        expired;
      v = '0;
      if (it.operation == OP_TICK) begin
         // both timers saturate instead of wrapping
         sum = {1'b0, up_ms} + it.delta_ms;
         up_ms = sum[32] ? '1 : sum[31:0];
         sum = {1'b0, since_scan_ms} + it.delta_ms;
         since_scan_ms = sum[32] ? '1 : sum[31:0];
         if (since_scan_ms >= scan_interval) begin
            since_scan_ms = '0;
            v.scan_due = 1'b1;
         end
      end else begin
         v.client_out = it.client;
         if (int'(it.client) < FLEET && it.client_running) begin
            lim = timeout_ms[it.client_priority];
            gap = it.time_now_ms - it.last_seen_in;   // modulo 2^32
            // never-updated client: grace until uptime reaches the limit
            expired = (it.last_seen_in == '0) ? (up_ms >= lim) : (gap >= lim);
            if (expired) begin
               if (restarts[it.client] < RESTART_LIMIT) begin
                  restarts[it.client] = restarts[it.client] + 4'd1;
                  v.action = ACT_RESTART;
                  v.restart_number = restarts[it.client];
                  v.last_seen_out = it.last_seen_in;
               end else if (!reported[it.client]) begin
                  reported[it.client] = 1'b1;
                  v.action = ACT_REPORT;
                  v.restart_number = restarts[it.client];
                  v.last_seen_out = it.last_seen_in;
               end
            end
         end
      end
      return v;
   endfunction

   function automatic req_type random_item();
      req_type it;
      it.operation       = 1'($urandom_range(0, 1));
      it.delta_ms        = 16'($urandom_range(0, 16'hFFFF));
      it.client          = 4'($urandom_range(0, 15));
      it.client_running  = 1'($urandom_range(0, 1));
      it.client_priority = 2'($urandom_range(0, 3));
      it.last_seen_in    = $urandom;
      it.time_now_ms     = $urandom;
      return it;
   endfunction

   // tick: unused fields carry noise, the block must ignore them
   function automatic req_type make_tick(input logic [15:0] dt);
      req_type it;
      it = random_item();
      it.operation = OP_TICK;
      it.delta_ms  = dt;
      return it;
   endfunction

   function automatic req_type make_check(input logic [3:0] client, input logic running,
                                          input logic [1:0] prio, input logic [31:0] last,
                                          input logic [31:0] now);
      req_type it;
      it = random_item();
      it.operation       = OP_CHECK;
      it.client          = client;
      it.client_running  = running;
      it.client_priority = prio;
      it.last_seen_in    = last;
      it.time_now_ms     = now;
      return it;
   endfunction

   // ---------------------------------------------------------------------
   // Sender: bursts of random length, random gaps between them.
   // Returns at the edge that accepted the item, with valid still high, so
   // the caller either sends the next item at once or drains.
   // ---------------------------------------------------------------------
   task automatic send_item(input req_type it, output rsp_type verdict);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // now and then a long burst with no idling at all
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      verdict = supervise(it);
      verdicts_due.push_back(verdict);
      items_sent++;
   endtask

   // drop valid and wait until every expected result has come back
   task automatic drain();
      if (req_valid) req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [31:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_TIMEOUT_CRITICAL: timeout_ms[PRIO_CRITICAL] = value;
         CSR_TIMEOUT_HIGH:     timeout_ms[PRIO_HIGH]     = value;
         CSR_TIMEOUT_NORMAL:   timeout_ms[PRIO_NORMAL]   = value;
         CSR_TIMEOUT_LOW:      timeout_ms[PRIO_LOW]      = value;
         CSR_SCAN_INTERVAL:    scan_interval             = value;
         default: ;   // spare index, block ignores it
      endcase
      csr_writes++;
   endtask

   // all five registers plus a junk write to a spare index, only while idle
   task automatic set_config(input logic [31:0] crit, input logic [31:0] high,
                             input logic [31:0] normal, input logic [31:0] low,
                             input logic [31:0] scan);
      drain();
      write_csr(CSR_TIMEOUT_CRITICAL, crit);
      write_csr(CSR_TIMEOUT_HIGH, high);
      write_csr(CSR_TIMEOUT_NORMAL, normal);
      write_csr(CSR_TIMEOUT_LOW, low);
      write_csr(CSR_SCAN_INTERVAL, scan);
      write_csr(CSR_INDEX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)), $urandom);
   endtask

   // ---------------------------------------------------------------------
   // Receiver: checks each result, stalls on its own pattern
   // ---------------------------------------------------------------------
   function automatic void check_verdict(input rsp_type got);
      rsp_type want;
      if (verdicts_due.size() == 0) begin
         $error("result item with nothing outstanding: %h", got);
         mismatches++;
      end else begin
         want = verdicts_due.pop_front();
         results_seen++;
         if (want.scan_due) scans_seen++;
         if (want.action == ACT_RESTART) restarts_seen++;
         if (want.action == ACT_REPORT) reports_seen++;
         if (got.scan_due !== want.scan_due) begin
            $error("scan_due: expected %0h, got %0h", want.scan_due, got.scan_due);
            mismatches++;
         end
         if (got.action !== want.action) begin
            $error("action: expected %0h, got %0h", want.action, got.action);
            mismatches++;
         end
         if (got.client_out !== want.client_out) begin
            $error("client_out: expected %0h, got %0h", want.client_out, got.client_out);
            mismatches++;
         end
         if (got.restart_number !== want.restart_number) begin
            $error("restart_number: expected %0h, got %0h",
                   want.restart_number, got.restart_number);
            mismatches++;
         end
         if (got.last_seen_out !== want.last_seen_out) begin
            $error("last_seen_out: expected %0h, got %0h",
                   want.last_seen_out, got.last_seen_out);
            mismatches++;
         end
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_verdict(rsp_data);
      // short stalls between ready runs, some of the runs long
      if (ready_hold != 0) begin
         ready_hold--;
      end else if (rsp_ready) begin
         rsp_ready <= 1'b0;
         ready_hold = $urandom_range(0, 6);
      end else begin
         rsp_ready <= 1'b1;
         ready_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                                  : $urandom_range(0, 12);
      end
   end

   // ---------------------------------------------------------------------
   // Directed tests (reset register values)
   // ---------------------------------------------------------------------

   // never-updated client: no timeout until uptime reaches the limit
   task automatic test_grace_period();
      rsp_type v;
      send_item(make_check(4'd1, 1'b1, PRIO_CRITICAL, '0, $urandom), v);  // uptime 0
      send_item(make_tick(16'd999), v);
      send_item(make_check(4'd1, 1'b1, PRIO_CRITICAL, '0, $urandom), v);  // 999, just short
      send_item(make_tick(16'd1), v);                                   // completes a scan
      send_item(make_check(4'd1, 1'b1, PRIO_CRITICAL, '0, $urandom), v);  // exactly at limit
   endtask

   task automatic test_scan_interval();
      rsp_type v;
      send_item(make_tick(16'd0), v);
      send_item(make_tick(16'hFFFF), v);
      send_item(make_tick(16'd999), v);
      send_item(make_tick(16'd1), v);
   endtask

   // three restarts, one overrun report, then silence; checks in a row on one client
   task automatic test_restart_limit();
      rsp_type v;
      send_item(make_check(4'd3, 1'b0, PRIO_CRITICAL, 32'd100, 32'd9000), v);  // not running
      repeat (RESTART_LIMIT + 2)
         send_item(make_check(4'd3, 1'b1, PRIO_CRITICAL, 32'd100, 32'd5100), v);
   endtask

   // each priority one below and exactly at its limit, plus wrapping time gaps
   task automatic test_priority_timeouts();
      rsp_type     v;
      logic [31:0] now;
      for (int p = 0; p < 4; p++) begin
         now = $urandom;
         send_item(make_check(4'(4 + 2 * p), 1'b1, 2'(p), now - (timeout_ms[p] - 1), now), v);
         send_item(make_check(4'(5 + 2 * p), 1'b1, 2'(p), now - timeout_ms[p], now), v);
      end
      send_item(make_check(4'd12, 1'b1, PRIO_CRITICAL, 32'd5, 32'd4), v);        // gap 2^32-1
      send_item(make_check(4'd13, 1'b1, PRIO_CRITICAL, 32'hFFFF_FFF0, 32'h10), v);  // gap 32
   endtask

   // ---------------------------------------------------------------------
   // Random traffic: mostly ticks with scan walks over the fleet, checks
   // aimed at the timeout boundary, and some fully random noise.
   // ---------------------------------------------------------------------
   task automatic run_traffic(input int count);
      req_type     it;
      rsp_type     v;
      int          walk_next;
      int          pick;
      int          c;
      logic [3:0]  prev_client;
      logic [31:0] lim;
      logic [31:0] gap;
      walk_next   = WALKED;   // no walk in progress
      prev_client = '0;
      for (int n = 0; n < count; n++) begin
         it = random_item();
         if (walk_next < WALKED) begin
            // walker reports on one client per item after a scan
            it.operation       = OP_CHECK;
            it.client          = 4'(walk_next);
            it.client_running  = fleet_running[walk_next];
            it.client_priority = fleet_prio[walk_next];
            it.last_seen_in    = fleet_seen[walk_next];
            it.time_now_ms     = wall_ms;
            walk_next++;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               it.operation = OP_TICK;
               case ($urandom_range(0, 9))
                  0:         it.delta_ms = '0;
                  7, 8, 9:   it.delta_ms = 16'($urandom_range(0, 16'hFFFF));
                  default:   it.delta_ms = 16'($urandom_range(1, 400));
               endcase
               wall_ms = wall_ms + it.delta_ms;
               // clients send heartbeats now and then, some change state
               if ($urandom_range(0, 2) == 0) fleet_seen[$urandom_range(0, WALKED - 1)] = wall_ms;
               if ($urandom_range(0, 19) == 0) begin
                  c = $urandom_range(0, WALKED - 1);
                  fleet_running[c] = ~fleet_running[c];
                  fleet_prio[c]    = 2'($urandom_range(0, 3));
               end
            end else if (pick < 85) begin
               // check with a silence close to the client's limit
               it.operation      = OP_CHECK;
               it.client         = ($urandom_range(0, 9) < 4) ? prev_client
                                                              : 4'($urandom_range(0, WALKED - 1));
               it.client_running = ($urandom_range(0, 9) != 0);
               lim = timeout_ms[it.client_priority];
               case ($urandom_range(0, 4))
                  0:       gap = lim - 1;
                  1:       gap = lim;
                  2:       gap = lim + 1;
                  3:       gap = $urandom_range(0, 3000);
                  default: gap = $urandom;
               endcase
               it.last_seen_in = it.time_now_ms - gap;
            end else if (it.operation == OP_CHECK && int'(it.client) >= WALKED) begin
               it.client_running = 1'b0;   // noise must not touch the held-back clients
            end
         end
         prev_client = it.client;
         send_item(it, v);
         if (v.scan_due) walk_next = 0;
      end
   endtask

   task automatic test_register_settings();
      run_traffic(400);                                      // reset values
      set_config('0, '0, '0, '0, '0);                        // everything expires, always scan
      run_traffic(300);
      set_config($urandom_range(1, 3000), $urandom_range(1, 3000), $urandom_range(1, 3000),
                 $urandom_range(1, 3000), $urandom_range(1, 2000));
      run_traffic(400);
      set_config('1, '1, '1, '1, '1);                        // largest limits
      run_traffic(300);
      set_config($urandom, $urandom, $urandom, $urandom, $urandom);
      run_traffic(300);
      set_config(RST_TIMEOUT_CRITICAL, RST_TIMEOUT_HIGH, RST_TIMEOUT_NORMAL,
                 RST_TIMEOUT_LOW, RST_SCAN_INTERVAL);
      run_traffic(300);
   endtask

   // largest limits: grace still running, time gaps at the top of the 32-bit range
   task automatic test_largest_limits();
      rsp_type v;
      set_config('1, '1, '1, '1, '1);
      send_item(make_tick(16'hFFFF), v);
      send_item(make_check(4'd14, 1'b1, 2'($urandom_range(0, 3)), '0, $urandom), v);  // grace
      send_item(make_check(4'd15, 1'b1, PRIO_LOW, 32'd1, '1), v);        // gap one short
      send_item(make_check(4'd15, 1'b1, PRIO_LOW, 32'd1, '0), v);        // gap 2^32-1
   endtask

   // ---------------------------------------------------------------------
   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_ready    = 1'b0;
      csr_write_en = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      timeout_ms[PRIO_CRITICAL] = RST_TIMEOUT_CRITICAL;
      timeout_ms[PRIO_HIGH]     = RST_TIMEOUT_HIGH;
      timeout_ms[PRIO_NORMAL]   = RST_TIMEOUT_NORMAL;
      timeout_ms[PRIO_LOW]      = RST_TIMEOUT_LOW;
      scan_interval = RST_SCAN_INTERVAL;
      up_ms         = '0;
      since_scan_ms = '0;
      wall_ms       = $urandom;
      for (int i = 0; i < FLEET; i++) begin
         restarts[i]      = '0;
         reported[i]      = 1'b0;
         fleet_seen[i]    = '0;               // never updated until a heartbeat
         fleet_running[i] = ($urandom_range(0, 4) != 0);
         fleet_prio[i]    = 2'($urandom_range(0, 3));
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_grace_period();
      test_scan_interval();
      test_restart_limit();
      test_priority_timeouts();
      test_register_settings();
      test_largest_limits();

      drain();
      repeat (6) @(posedge clock);   // catch stray results
      $display("covered %0d items with %0d results: %0d scans, %0d restarts, %0d reports",
               items_sent, results_seen, scans_seen, restarts_seen, reports_seen);
      $display("%0d register writes over reset, zero, small, largest and random settings",
               csr_writes);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // hang guard, several times the slowest legal run
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
